>>> sv/aes256_block_cipher_top_macros.svh
`ifndef AES256_BLOCK_CIPHER_TOP_MACROS_SVH
`define AES256_BLOCK_CIPHER_TOP_MACROS_SVH

// Assertion helpers. Each one is sampled on clk and is off while arst_n is low.
`define AES_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/aes_pkg.sv
package aes_pkg;

	localparam int NUM_ROUNDS = 14;
	localparam int RK_ROWS = NUM_ROUNDS + 1;
	localparam int ROW_W = $clog2(RK_ROWS);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROUNDS);
	localparam int NUM_KEY_REGS = 4;
	localparam int IDX_W = $clog2(NUM_KEY_REGS);

	typedef struct packed {
		logic load;
		logic exp_en;
		logic [ROW_W-1:0] exp_row;
		logic [ROW_W-1:0] rd_step;
		logic run_en;
		logic [ROW_W-1:0] step;
		logic out_load;
	} cmd_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xt(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		logic [31:0] t;
		for (int j = 0; j < 4; j++) t[8*j +: 8] = SBOX[w[8*j +: 8]];
		return t;
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] s);
		logic [127:0] t;
		for (int k = 0; k < 16; k++) t[8*k +: 8] = SBOX[s[8*k +: 8]];
		return t;
	endfunction

	function automatic logic [127:0] inv_sub_bytes(input logic [127:0] s);
		logic [127:0] t;
		for (int k = 0; k < 16; k++) t[8*k +: 8] = INV_SBOX[s[8*k +: 8]];
		return t;
	endfunction

	function automatic logic [127:0] shift_rows(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(c*4+r) +: 8] = s[8*(((c+r)&3)*4+r) +: 8];
		return t;
	endfunction

	function automatic logic [127:0] inv_shift_rows(input logic [127:0] s);
		logic [127:0] t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[8*(((c+r)&3)*4+r) +: 8] = s[8*(c*4+r) +: 8];
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) a[j] = s[8*(c*4+j) +: 8];
			for (int r = 0; r < 4; r++)
				t[8*(c*4+r) +: 8] = xt(a[r]) ^ xt(a[(r+1)&3]) ^ a[(r+1)&3]
					^ a[(r+2)&3] ^ a[(r+3)&3];
		end
		return t;
	endfunction

	function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a [4];
		logic [7:0] x1 [4];
		logic [7:0] x2 [4];
		logic [7:0] x3 [4];
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				a[j] = s[8*(c*4+j) +: 8];
				x1[j] = xt(a[j]);
				x2[j] = xt(x1[j]);
				x3[j] = xt(x2[j]);
			end
			for (int r = 0; r < 4; r++)
				t[8*(c*4+r) +: 8] = (x3[r] ^ x2[r] ^ x1[r])
					^ (x3[(r+1)&3] ^ x1[(r+1)&3] ^ a[(r+1)&3])
					^ (x3[(r+2)&3] ^ x2[(r+2)&3] ^ a[(r+2)&3])
					^ (x3[(r+3)&3] ^ a[(r+3)&3]);
		end
		return t;
	endfunction

endpackage

>>> sv/aes_if.sv
interface aes_in_if;
	logic valid;
	logic ready;
	logic opcode;
	logic [63:0] data_low;
	logic [63:0] data_high;
	modport source(output valid, output opcode, output data_low, output data_high, input ready);
	modport sink(input valid, input opcode, input data_low, input data_high, output ready);
endinterface

interface aes_out_if;
	logic valid;
	logic ready;
	logic [63:0] result_low;
	logic [63:0] result_high;
	modport source(output valid, output result_low, output result_high, input ready);
	modport sink(input valid, input result_low, input result_high, output ready);
endinterface

>>> sv/aes256_block_cipher_top.sv
// AES-256 block cipher, one 128-bit block at a time, encrypt or decrypt by the opcode bit.
// After acceptance, a block first passes a step that starts the round-key read, then the initial
// key addition and the fourteen rounds (one round per cycle from the round-key memory), and
// last a step that moves the block into the output register once it is empty or being read.
// After reset or any key register write, the next block first waits while the key is
// expanded, one 128-bit round-key row per cycle. A new block is taken while a
// finished result still waits in the output register.
module aes256_block_cipher_top (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [aes_pkg::IDX_W-1:0] wr_index,
	input  logic [63:0] wr_data,
	aes_in_if.sink din,
	aes_out_if.source dout
);

	aes_pkg::cmd_t cmd;

	aes_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.in_valid(din.valid),
		.in_ready(din.ready),
		.out_valid(dout.valid),
		.out_ready(dout.ready),
		.cmd(cmd)
	);

	aes_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.cmd(cmd),
		.opcode(din.opcode),
		.data_low(din.data_low),
		.data_high(din.data_high),
		.result_low(dout.result_low),
		.result_high(dout.result_high)
	);

endmodule

>>> sv/aes_ctrl.sv
`include "aes256_block_cipher_top_macros.svh"

module aes_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output aes_pkg::cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_PREP = 3'd2;
	localparam logic [2:0] ST_RUN = 3'd3;
	localparam logic [2:0] ST_FIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [aes_pkg::ROW_W-1:0] cnt_q;
	logic [aes_pkg::ROW_W-1:0] cnt_d;
	logic keys_ready_q;
	logic out_valid_q;
	logic accept;
	logic cnt_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign cnt_last = (cnt_q == aes_pkg::LAST_ROW);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.exp_row = cnt_q;
		cmd.step = cnt_q;
		cmd.rd_step = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					cnt_d = '0;
					state_d = keys_ready_q ? ST_PREP : ST_EXPAND;
				end
			end
			ST_EXPAND: begin
				cmd.exp_en = 1'b1;
				if (cnt_last) begin
					cnt_d = '0;
					state_d = ST_PREP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_PREP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.run_en = 1'b1;
				if (cnt_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.rd_step = cnt_q + 1'b1;
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			keys_ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (wr_en) begin
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_EXPAND && cnt_last) begin
				keys_ready_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`AES_ASSERT_NEXT(a_run_ends, (state_q == ST_RUN) && cnt_last, state_q == ST_FIN, "Round sequence did not end after the last round.")
	`AES_ASSERT_SAME(a_keys_before_run, cmd.run_en, keys_ready_q, "A round ran without an expanded key.")
	`AES_ASSERT_NEXT(a_accept_next, accept, (state_q == ST_EXPAND) || (state_q == ST_PREP), "An accepted word did not start processing.")
	`AES_ASSERT_NEXT(a_out_loaded, cmd.out_load, out_valid_q, "A finished result was not presented.")

endmodule

>>> sv/aes_dp.sv
module aes_dp (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [aes_pkg::IDX_W-1:0] wr_index,
	input  logic [63:0] wr_data,
	input  aes_pkg::cmd_t cmd,
	input  logic opcode,
	input  logic [63:0] data_low,
	input  logic [63:0] data_high,
	output logic [63:0] result_low,
	output logic [63:0] result_high
);

	logic [63:0] key_q [aes_pkg::NUM_KEY_REGS];
	logic [255:0] key_flat;
	logic [255:0] kw_q;
	logic [127:0] rk_mem [aes_pkg::RK_ROWS];
	logic [127:0] rk_q;
	logic [127:0] st_q;
	logic [127:0] res_q;
	logic op_q;
	logic [31:0] prev_w;
	logic [31:0] t_w;
	logic [7:0] rcon;
	logic [127:0] new_row;
	logic [127:0] wr_row;
	logic [aes_pkg::ROW_W-1:0] rd_row;
	logic [127:0] enc_last;
	logic [127:0] dec_pre;
	logic [127:0] st_next;

	assign key_flat = {key_q[3], key_q[2], key_q[1], key_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < aes_pkg::NUM_KEY_REGS; i++) key_q[i] <= '0;
		end else if (wr_en) begin
			key_q[wr_index] <= wr_data;
		end
	end

	assign prev_w = kw_q[255:224];
	assign rcon = 8'h01 << (cmd.exp_row[3:1] - 3'd1);
	assign t_w = cmd.exp_row[0] ? aes_pkg::sub_word(prev_w)
		: (aes_pkg::sub_word({prev_w[7:0], prev_w[31:8]}) ^ {24'h0, rcon});

	always_comb begin
		new_row[31:0] = kw_q[31:0] ^ t_w;
		new_row[63:32] = kw_q[63:32] ^ new_row[31:0];
		new_row[95:64] = kw_q[95:64] ^ new_row[63:32];
		new_row[127:96] = kw_q[127:96] ^ new_row[95:64];
	end

	always_comb begin
		priority if (cmd.exp_row == '0) begin
			wr_row = key_flat[127:0];
		end else if (cmd.exp_row == aes_pkg::ROW_W'(1)) begin
			wr_row = key_flat[255:128];
		end else begin
			wr_row = new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exp_en) begin
			if (cmd.exp_row == '0) begin
				kw_q <= key_flat;
			end else if (cmd.exp_row != aes_pkg::ROW_W'(1)) begin
				kw_q <= {new_row, kw_q[255:128]};
			end
		end
	end

	assign rd_row = op_q ? (aes_pkg::LAST_ROW - cmd.rd_step) : cmd.rd_step;

	always_ff @(posedge clk) begin
		if (cmd.exp_en) begin
			rk_mem[cmd.exp_row] <= wr_row;
		end
		rk_q <= rk_mem[rd_row];
	end

	assign enc_last = aes_pkg::shift_rows(aes_pkg::sub_bytes(st_q));
	assign dec_pre = aes_pkg::inv_sub_bytes(aes_pkg::inv_shift_rows(st_q));

	always_comb begin
		priority if (cmd.step == '0) begin
			st_next = st_q ^ rk_q;
		end else if (!op_q) begin
			st_next = (cmd.step == aes_pkg::LAST_ROW) ? (enc_last ^ rk_q)
				: (aes_pkg::mix_columns(enc_last) ^ rk_q);
		end else begin
			st_next = (cmd.step == aes_pkg::LAST_ROW) ? (dec_pre ^ rk_q)
				: aes_pkg::inv_mix_columns(dec_pre ^ rk_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q <= {data_high, data_low};
			op_q <= opcode;
		end else if (cmd.run_en) begin
			st_q <= st_next;
		end
		if (cmd.out_load) begin
			res_q <= st_q;
		end
	end

	assign result_low = res_q[63:0];
	assign result_high = res_q[127:64];

endmodule
